### hdl/b64e_pkg.sv
// shared types, constants and the symbol alphabet for the base64 stream encoder
// no dependencies
`default_nettype none

package b64e_pkg;

    localparam int SYM_W     = 7;
    localparam int MAX_SYMS  = 4;
    localparam int IDX_W     = $clog2(MAX_SYMS);
    localparam int QDEPTH    = 2;
    localparam int QAW       = $clog2(QDEPTH);
    localparam int QCW       = $clog2(QDEPTH + 1);

    localparam logic [SYM_W-1:0] SYM_PAD   = 7'd61;
    localparam logic [SYM_W-1:0] SYM_UPPER = 7'd65;
    localparam logic [SYM_W-1:0] SYM_LOWER = 7'd97;
    localparam logic [SYM_W-1:0] SYM_DIGIT = 7'd48;
    localparam logic [SYM_W-1:0] SYM_PLUS  = 7'd43;
    localparam logic [SYM_W-1:0] SYM_SLASH = 7'd47;

    // position within the three-byte group
    typedef enum logic [2:0]
    {
        PH0 = 3'b001,
        PH1 = 3'b010,
        PH2 = 3'b100
    } b64e_phase_t;

    // symbols of one input byte, waiting for the output side
    typedef struct packed
    {
        logic [MAX_SYMS-1:0][SYM_W-1:0] sym;
        logic [IDX_W-1:0]               last_idx;
        logic                           fin;
    } b64e_pkt_t;

    function automatic logic [SYM_W-1:0] b64_char(input logic [5:0] v);
        logic [SYM_W-1:0] c;
        c = SYM_SLASH;
        case (v) inside
            [6'd0:6'd25]:  c = SYM_UPPER + {1'b0, v};
            [6'd26:6'd51]: c = SYM_LOWER + {1'b0, v} - 7'd26;
            [6'd52:6'd61]: c = SYM_DIGIT + {1'b0, v} - 7'd52;
            6'd62:         c = SYM_PLUS;
            default:       c = SYM_SLASH;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### hdl/b64e_front.sv
// accepts raw bytes, tracks group phase and leftover bits, builds symbol packets
// depends on b64e_pkg
`default_nettype none

module b64e_front
    import b64e_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] data_byte,
    input  wire logic       final_byte,
    input  wire logic       in_valid,
    input  wire logic       q_full,
    output logic            push,
    output b64e_pkt_t       pkt
);

    b64e_phase_t phase_reg, phase_next;
    logic [3:0]  pending_reg, pending_next;

    assign push = in_valid && !q_full;

    always_comb
    begin
        phase_next   = phase_reg;
        pending_next = pending_reg;
        pkt.sym      = '{default: SYM_PAD};
        pkt.fin      = final_byte;
        pkt.last_idx = '0;
        case (phase_reg)
            PH1:
            begin
                pkt.sym[0] = b64_char({pending_reg[1:0], data_byte[7:4]});
                if (final_byte)
                begin
                    pkt.sym[1]   = b64_char({data_byte[3:0], 2'b00});
                    pkt.last_idx = IDX_W'(2);
                    phase_next   = PH0;
                    pending_next = '0;
                end
                else
                begin
                    phase_next   = PH2;
                    pending_next = data_byte[3:0];
                end
            end
            PH2:
            begin
                pkt.sym[0]   = b64_char({pending_reg, data_byte[7:6]});
                pkt.sym[1]   = b64_char(data_byte[5:0]);
                pkt.last_idx = IDX_W'(1);
                phase_next   = PH0;
                pending_next = '0;
            end
            default:
            begin
                pkt.sym[0] = b64_char(data_byte[7:2]);
                if (final_byte)
                begin
                    pkt.sym[1]   = b64_char({data_byte[1:0], 4'b0000});
                    pkt.last_idx = IDX_W'(3);
                    phase_next   = PH0;
                    pending_next = '0;
                end
                else
                begin
                    phase_next   = PH1;
                    pending_next = {2'b00, data_byte[1:0]};
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH0;
            pending_reg <= '0;
        end
        else if (push)
        begin
            phase_reg   <= phase_next;
            pending_reg <= pending_next;
        end
    end

endmodule

`default_nettype wire

### hdl/b64e_queue.sv
// short packet queue between the byte front end and the symbol back end
// depends on b64e_pkg
`default_nettype none

module b64e_queue
    import b64e_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  b64e_pkt_t push_pkt,
    input  wire logic pop,
    output logic      full,
    output logic      head_valid,
    output b64e_pkt_t head_pkt
);

    b64e_pkt_t        entry_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   count_reg, count_next;

    assign full       = (count_reg == QCW'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_pkt   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_pkt;
        end
    end

endmodule

`default_nettype wire

### hdl/b64e_back.sv
// walks the head packet one symbol per cycle into the output register while out_stall is low
// depends on b64e_pkg
`default_nettype none

module b64e_back
    import b64e_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              head_valid,
    input  b64e_pkt_t              head_pkt,
    output logic                   pop,
    input  wire logic              out_stall,
    output logic                   out_valid,
    output logic [SYM_W-1:0]       symbol,
    output logic                   last_symbol
);

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic [SYM_W-1:0] sym_reg;
    logic             last_reg;
    logic             out_free;
    logic             issue;
    logic             pkt_done;

    assign out_free = !valid_reg || !out_stall;
    assign issue    = head_valid && out_free;
    assign pkt_done = (idx_reg == head_pkt.last_idx);
    assign pop      = issue && pkt_done;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (out_free)
        begin
            valid_next = head_valid;
        end
        if (pop)
        begin
            idx_next = '0;
        end
        else if (issue)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            sym_reg  <= head_pkt.sym[idx_reg];
            last_reg <= head_pkt.fin && pkt_done;
        end
    end

    assign out_valid   = valid_reg;
    assign symbol      = sym_reg;
    assign last_symbol = last_reg;

endmodule

`default_nettype wire

### hdl/base64_stream_encoder.sv
// top level of the base64 stream encoder: front end, packet queue, symbol back end
// depends on b64e_pkg, b64e_front, b64e_queue, b64e_back
`default_nettype none

// Padded base64 encoder with the standard alphabet. Each input transfer carries one raw
// byte and a final-byte mark; each output transfer carries one ASCII symbol, with
// last_symbol set on the final symbol of a message. A byte yields one or two symbols, and
// a final byte flushes the partial group and pads with '=' to four symbols per group, so a
// byte yields one to four symbols. The output register sends one symbol per cycle while
// out_stall is low, which sets the rate. Input bytes are taken every cycle while the
// two-entry packet queue has room; a byte's packet is registered in the queue, then its
// first symbol in the output register. An empty message produces no symbols.
module base64_stream_encoder
    import b64e_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [7:0]       data_byte,
    input  wire logic             final_byte,
    input  wire logic             in_valid,
    output logic                  in_stall,
    output logic [SYM_W-1:0]      symbol,
    output logic                  last_symbol,
    output logic                  out_valid,
    input  wire logic             out_stall
);

    b64e_pkt_t push_pkt;
    b64e_pkt_t head_pkt;
    logic      push;
    logic      pop;
    logic      q_full;
    logic      head_valid;

    assign in_stall = q_full;

    b64e_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .in_valid   (in_valid),
        .q_full     (q_full),
        .push       (push),
        .pkt        (push_pkt)
    );

    b64e_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_pkt   (push_pkt),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_pkt   (head_pkt)
    );

    b64e_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_pkt    (head_pkt),
        .pop         (pop),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .symbol      (symbol),
        .last_symbol (last_symbol)
    );

endmodule

`default_nettype wire

### hdl/b64e_checker.sv
// port-level checks for the base64 stream encoder, bound to the top level
// depends on b64e_pkg and base64_stream_encoder
`default_nettype none

module b64e_checker
    import b64e_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_stall,
    input wire logic [SYM_W-1:0] symbol,
    input wire logic             last_symbol,
    input wire logic             out_valid,
    input wire logic             out_stall
);

    // stalled output holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(symbol) && $stable(last_symbol))
        else $error("output changed while stalled");

    // only alphabet characters or padding leave the block
    a_legal_sym: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (symbol >= 7'd65 && symbol <= 7'd90) ||
                      (symbol >= 7'd97 && symbol <= 7'd122) ||
                      (symbol >= 7'd48 && symbol <= 7'd57) ||
                      symbol == SYM_PLUS || symbol == SYM_SLASH || symbol == SYM_PAD)
        else $error("illegal symbol");

    // a full queue implies the output side is busy
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled while output idle");

    // no input stall and no valid output directly after reset release
    a_reset_free: assert property (@(posedge clk)
        !rst_n |=> !in_stall && !out_valid)
        else $error("busy right after reset");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .symbol      (symbol),
    .last_symbol (last_symbol),
    .out_valid   (out_valid),
    .out_stall   (out_stall)
);

`default_nettype wire
